FILE: rtl/rk4_pkg.sv
// shared types, constants and arithmetic helpers for the rk4 step block
`timescale 1ns / 1ps

package rk4_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 35;
    localparam int DIV_W     = 36;
    localparam int DIGIT_W   = 4;
    localparam int DIV_STEPS = DIV_W / DIGIT_W;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int STAGE_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERACTION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE  = 2'd3;

    localparam logic [STAGE_W-1:0] STAGE_K1 = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_K2 = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_K3 = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_K4 = 2'd3;

    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

    localparam logic signed [DATA_W-1:0] RST_STEP   = DATA_W'(ONE_Q);
    localparam logic signed [DATA_W-1:0] RST_GROWTH = DATA_W'(-((8 * ONE_Q + 5) / 10));
    localparam logic signed [DATA_W-1:0] RST_INTER  = DATA_W'(-((ONE_Q + 10) / 20));
    localparam logic signed [DATA_W-1:0] RST_INIT   = DATA_W'(ONE_Q / 2);

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    // floor(s/6) = floor(floor(s/2)/3); the halved sum is biased positive by a multiple of 3
    localparam logic [DIV_W-1:0]        DIV_OFFSET = DIV_W'(64'd3 << 31);
    localparam logic signed [ACC_W-1:0] QUO_BIAS   = ACC_W'(64'sd1 <<< 31);

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } clip_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] q;
        logic [1:0]         r;
    } div_digit_t;

    typedef struct packed {
        logic                restart;
        logic                start;
        logic                xin_en;
        logic                mul1_en;
        logic                addr_en;
        logic                mul2_en;
        logic                mul3_en;
        logic                k_en;
        logic                prep_en;
        logic                div_en;
        logic                fin_en;
        logic                out_load;
        logic [STAGE_W-1:0]  stage;
    } dp_cmd_t;

    function automatic clip_t clip32(input logic signed [63:0] v);
        clip_t res;
        if (v > MAX32)
        begin
            res.val = DATA_W'(MAX32);
            res.sat = 1'b1;
        end
        else if (v < MIN32)
        begin
            res.val = DATA_W'(MIN32);
            res.sat = 1'b1;
        end
        else
        begin
            res.val = DATA_W'(v);
            res.sat = 1'b0;
        end
        return res;
    endfunction

    // one radix-16 digit of a division by 3, incoming remainder below 3
    function automatic div_digit_t div3_digit(input logic [5:0] v);
        div_digit_t res;
        logic [5:0] rem6;
        res.q = '0;
        for (int j = 1; j < 16; j++)
        begin
            if (v >= 6'(3 * j))
                res.q = DIGIT_W'(j);
        end
        rem6  = v - 6'(res.q) * 6'd3;
        res.r = rem6[1:0];
        return res;
    endfunction

endpackage

FILE: rtl/rk4_ctrl.sv
// sequencer for the rk4 step: stage order, divider count and output handshake
`timescale 1ns / 1ps

module rk4_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              restart,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output rk4_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_XIN  = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_ADDR = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_MUL3 = 4'd5;
    localparam logic [3:0] S_KST  = 4'd6;
    localparam logic [3:0] S_PREP = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]                  state_reg, state_next;
    logic [rk4_pkg::STAGE_W-1:0] stage_reg, stage_next;
    logic [rk4_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.stage  = stage_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        cmd.restart = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        stage_next = rk4_pkg::STAGE_K1;
                    end
                    state_next = restart ? S_DONE : S_XIN;
                end
            end
            S_XIN:
            begin
                cmd.xin_en = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1_en = 1'b1;
                state_next  = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr_en = 1'b1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2_en = 1'b1;
                state_next  = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3_en = 1'b1;
                state_next  = S_KST;
            end
            S_KST:
            begin
                cmd.k_en = 1'b1;
                if (stage_reg == rk4_pkg::STAGE_K4)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    stage_next = stage_reg + rk4_pkg::STAGE_W'(1);
                    state_next = S_XIN;
                end
            end
            S_PREP:
            begin
                cmd.prep_en = 1'b1;
                cnt_next    = '0;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_en = 1'b1;
                cnt_next   = cnt_reg + rk4_pkg::CNT_W'(1);
                if (cnt_reg == rk4_pkg::CNT_W'(rk4_pkg::DIV_STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stage_reg     <= rk4_pkg::STAGE_K1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/rk4_dp.sv
// datapath for the rk4 step: registers, shared multiplier, accumulator, divide by six
`timescale 1ns / 1ps

module rk4_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [rk4_pkg::CFG_IDX_W-1:0]        cfg_wr_idx,
    input  logic [rk4_pkg::DATA_W-1:0]           cfg_wr_data,
    input  rk4_pkg::dp_cmd_t                     cmd,
    output logic signed [rk4_pkg::DATA_W-1:0]    value_out,
    output logic                                 saturated
);

    logic signed [rk4_pkg::DATA_W-1:0] step_reg;
    logic signed [rk4_pkg::DATA_W-1:0] growth_reg;
    logic signed [rk4_pkg::DATA_W-1:0] inter_reg;
    logic signed [rk4_pkg::DATA_W-1:0] init_reg;
    logic signed [rk4_pkg::DATA_W-1:0] cur_reg;
    logic signed [rk4_pkg::DATA_W-1:0] res_val_reg;
    logic                              sat_reg;

    logic signed [rk4_pkg::DATA_W-1:0] xin_reg;
    logic signed [rk4_pkg::DATA_W-1:0] a_reg;
    logic signed [rk4_pkg::DATA_W-1:0] k_reg;
    logic signed [rk4_pkg::PROD_W-1:0] prod_reg;
    logic signed [rk4_pkg::ACC_W-1:0]  acc_reg;
    logic [rk4_pkg::DIV_W-1:0]         div_reg;
    logic [rk4_pkg::DIV_W-1:0]         quo_reg;
    logic [1:0]                        rem_reg;

    logic signed [rk4_pkg::DATA_W-1:0] value_out_reg;
    logic                              saturated_reg;

    logic signed [rk4_pkg::PROD_W-1:0] prod_sh;
    rk4_pkg::clip_t                    prod_clip;
    rk4_pkg::clip_t                    xin_clip;
    rk4_pkg::clip_t                    add_clip;
    rk4_pkg::clip_t                    fin_clip;
    logic signed [rk4_pkg::DATA_W-1:0] addend;
    logic signed [rk4_pkg::DATA_W-1:0] mul_a;
    logic signed [rk4_pkg::DATA_W-1:0] mul_b;
    logic signed [rk4_pkg::ACC_W-1:0]  k_ext;
    logic signed [rk4_pkg::ACC_W-1:0]  k_term;
    logic signed [rk4_pkg::ACC_W-1:0]  acc_half;
    logic signed [rk4_pkg::ACC_W-1:0]  quot;
    rk4_pkg::div_digit_t               digit;

    assign prod_sh   = prod_reg >>> rk4_pkg::FRAC_BITS;
    assign prod_clip = rk4_pkg::clip32(prod_sh);

    // stage input offset: none, k/2, k/2, k
    always_comb
    begin
        unique case (cmd.stage)
            rk4_pkg::STAGE_K1: addend = '0;
            rk4_pkg::STAGE_K2: addend = k_reg >>> 1;
            rk4_pkg::STAGE_K3: addend = k_reg >>> 1;
            rk4_pkg::STAGE_K4: addend = k_reg;
            default:           addend = '0;
        endcase
    end

    assign xin_clip = rk4_pkg::clip32(rk4_pkg::PROD_W'(cur_reg) + rk4_pkg::PROD_W'(addend));
    assign add_clip = rk4_pkg::clip32(rk4_pkg::PROD_W'(growth_reg)
                                      + rk4_pkg::PROD_W'(prod_clip.val));

    always_comb
    begin
        priority if (cmd.mul1_en)
        begin
            mul_a = inter_reg;
            mul_b = xin_reg;
        end
        else if (cmd.mul2_en)
        begin
            mul_a = a_reg;
            mul_b = xin_reg;
        end
        else
        begin
            mul_a = step_reg;
            mul_b = prod_clip.val;
        end
    end

    assign k_ext  = rk4_pkg::ACC_W'(prod_clip.val);
    assign k_term = (cmd.stage == rk4_pkg::STAGE_K2 || cmd.stage == rk4_pkg::STAGE_K3)
                    ? (k_ext <<< 1) : k_ext;

    assign acc_half = acc_reg >>> 1;
    assign digit    = rk4_pkg::div3_digit({rem_reg,
                                           div_reg[rk4_pkg::DIV_W-1 -: rk4_pkg::DIGIT_W]});
    assign quot     = $signed(quo_reg[rk4_pkg::ACC_W-1:0]) - rk4_pkg::QUO_BIAS;
    assign fin_clip = rk4_pkg::clip32(rk4_pkg::PROD_W'(cur_reg) + rk4_pkg::PROD_W'(quot));

    // configuration, population state and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= rk4_pkg::RST_STEP;
            growth_reg <= rk4_pkg::RST_GROWTH;
            inter_reg  <= rk4_pkg::RST_INTER;
            init_reg   <= rk4_pkg::RST_INIT;
            cur_reg    <= rk4_pkg::RST_INIT;
            sat_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_wr_idx)
                    rk4_pkg::CFG_STEP_SIZE:   step_reg   <= cfg_wr_data;
                    rk4_pkg::CFG_GROWTH_RATE: growth_reg <= cfg_wr_data;
                    rk4_pkg::CFG_INTERACTION: inter_reg  <= cfg_wr_data;
                    rk4_pkg::CFG_INIT_VALUE:  init_reg   <= cfg_wr_data;
                    default:                  init_reg   <= init_reg;
                endcase
            end
            if (cmd.restart)
            begin
                cur_reg <= init_reg;
                sat_reg <= 1'b0;
            end
            else if (cmd.start)
            begin
                sat_reg <= 1'b0;
            end
            else if (cmd.xin_en)
            begin
                sat_reg <= sat_reg | xin_clip.sat;
            end
            else if (cmd.addr_en)
            begin
                sat_reg <= sat_reg | prod_clip.sat | add_clip.sat;
            end
            else if (cmd.mul3_en || cmd.k_en)
            begin
                sat_reg <= sat_reg | prod_clip.sat;
            end
            else if (cmd.fin_en)
            begin
                cur_reg <= fin_clip.val;
                sat_reg <= sat_reg | fin_clip.sat;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.restart)
            res_val_reg <= init_reg;
        else if (cmd.start)
            res_val_reg <= cur_reg;

        if (cmd.start)
            acc_reg <= '0;
        else if (cmd.k_en)
            acc_reg <= acc_reg + k_term;

        if (cmd.xin_en)
            xin_reg <= xin_clip.val;
        if (cmd.addr_en)
            a_reg <= add_clip.val;
        if (cmd.k_en)
            k_reg <= prod_clip.val;
        if (cmd.mul1_en || cmd.mul2_en || cmd.mul3_en)
            prod_reg <= rk4_pkg::PROD_W'(mul_a) * rk4_pkg::PROD_W'(mul_b);

        if (cmd.prep_en)
        begin
            div_reg <= rk4_pkg::DIV_W'(acc_half) + rk4_pkg::DIV_OFFSET;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.div_en)
        begin
            div_reg <= div_reg << rk4_pkg::DIGIT_W;
            quo_reg <= {quo_reg[rk4_pkg::DIV_W-rk4_pkg::DIGIT_W-1:0], digit.q};
            rem_reg <= digit.r;
        end

        if (cmd.out_load)
        begin
            value_out_reg <= res_val_reg;
            saturated_reg <= sat_reg;
        end
    end

    assign value_out = value_out_reg;
    assign saturated = saturated_reg;

endmodule

FILE: rtl/rk4_logistic_step.sv
// top level of the fixed-point rk4 integrator for dx/dt = (r + b*x)*x
`timescale 1ns / 1ps

// One RK4 step of dx/dt = (r + b*x)*x in signed Q8.24 with saturation. A transfer with
// restart high reloads the population from initial_value and returns it with saturated
// low. A transfer with restart low returns the population before the step and advances
// it: four slope evaluations through the one shared 32x32 multiplier (three products per
// slope), then a radix-16 division of the weighted sum by six and the final saturating
// add. One item is in work at a time; the finished result sits in an output register,
// so a new item is taken while it waits. Registers are written through
// cfg_wr_en/cfg_wr_idx/cfg_wr_data; the user must write them only while the block is
// idle, and the block itself does not enforce this.

module rk4_logistic_step
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [rk4_pkg::CFG_IDX_W-1:0]        cfg_wr_idx,
    input  logic [rk4_pkg::DATA_W-1:0]           cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 restart,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rk4_pkg::DATA_W-1:0]    value_out,
    output logic                                 saturated
);

    rk4_pkg::dp_cmd_t cmd;

    rk4_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .restart   (restart),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    rk4_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .value_out   (value_out),
        .saturated   (saturated)
    );

endmodule
